// ----- rtl/core/smb_pkg.sv -----
// shared constants, types and codes of the stereo mix bus
package smb_pkg;

  localparam int NUM_STRIPS = 4;
  localparam int FRAMES     = 1024;

  localparam int MAX_STRIPS = 4;
  localparam int STRIP_W    = 2;
  localparam int FRAME_W    = 10;
  localparam int SAMP_W     = 24;
  localparam int GAIN_W     = 16;
  localparam int SUM_W      = 40;
  localparam int PEAK_W     = 27;
  localparam int MUTE_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int RND_SH   = 12;
  localparam int ROUND    = 2048;
  localparam int PROD0_W  = SAMP_W + GAIN_W + 1;
  localparam int VAL_W    = PROD0_W - RND_SH;
  localparam int PROD1_W  = SUM_W + GAIN_W + 1;
  localparam int REND_W   = PROD1_W - RND_SH;
  localparam int AW       = $clog2(FRAMES);

  localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(4096);
  localparam logic [PEAK_W-1:0] PEAK_MAX   = {PEAK_W{1'b1}};

  localparam logic FUNC_MIX    = 1'b0;
  localparam logic FUNC_RENDER = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_STRIP_GAIN_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_GAIN_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_GAIN_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_GAIN_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MUTE_MASK    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_GAIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO_OUT   = 3'd6;

  typedef struct packed {
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] s1_addr;
    logic          we;
    logic          wr_sum;
    logic [AW-1:0] wr_addr;
    logic          s2_en;
    logic          s2_render;
    logic          s2_zero;
  } lane_ctl_t;

  typedef struct packed {
    logic render;
    logic track;
    logic publish;
    logic ignored;
    logic wr_l;
    logic wr_r;
    logic zero_l;
    logic zero_r;
  } item_flags_t;

endpackage

// ----- rtl/core/smb_ram.sv -----
// generic single write port ram with registered read
module smb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/smb_lane.sv -----
// one channel lane: strip gain, saturating accumulate, master gain and clip
module smb_lane import smb_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lane_ctl_t                ctl_i,
  input  logic signed [SAMP_W-1:0] sample_i,
  input  logic [GAIN_W-1:0]        gain_i,
  input  logic [GAIN_W-1:0]        master_i,
  output logic signed [VAL_W-1:0]  val_o
);

  localparam logic signed [SUM_W-1:0]  SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0]  SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [SAMP_W-1:0] S_MAX   = {1'b0, {(SAMP_W-1){1'b1}}};
  localparam logic signed [SAMP_W-1:0] S_MIN   = {1'b1, {(SAMP_W-1){1'b0}}};

  logic signed [PROD0_W-1:0] mix_rnd;
  logic signed [VAL_W-1:0]   gv1_q, gv2_q;
  logic [SUM_W-1:0]          rdata;
  logic signed [SUM_W-1:0]   old_sum;
  logic signed [SUM_W:0]     acc;
  logic signed [SUM_W-1:0]   sum_sat;
  logic [SUM_W-1:0]          wdata;
  logic                      lw_v_q;
  logic [AW-1:0]             lw_addr_q;
  logic [SUM_W-1:0]          lw_data_q;
  logic signed [PROD1_W-1:0] rp_d, rp_q;
  logic signed [PROD1_W-1:0] rp_rnd;
  logic signed [REND_W-1:0]  rend;
  logic [REND_W-SAMP_W:0]    rend_hi;
  logic signed [SAMP_W-1:0]  clip;

  assign mix_rnd = sample_i * $signed({1'b0, gain_i}) + PROD0_W'(ROUND);

  smb_ram #(.WIDTH(SUM_W), .DEPTH(FRAMES)) u_sum (
    .clk_i   (clk_i),
    .we_i    (ctl_i.we),
    .waddr_i (ctl_i.wr_addr),
    .wdata_i (wdata),
    .re_i    (ctl_i.rd_en),
    .raddr_i (ctl_i.rd_addr),
    .rdata_o (rdata)
  );

  always_comb begin
    old_sum = (lw_v_q && (lw_addr_q == ctl_i.s1_addr)) ? $signed(lw_data_q) : $signed(rdata);
    acc     = {old_sum[SUM_W-1], old_sum} + {{(SUM_W+1-VAL_W){gv1_q[VAL_W-1]}}, gv1_q};
    if (acc[SUM_W] != acc[SUM_W-1]) begin
      sum_sat = acc[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = acc[SUM_W-1:0];
    end
    wdata = ctl_i.wr_sum ? sum_sat : '0;
    rp_d  = old_sum * $signed({1'b0, master_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_v_q <= 1'b0;
    end else if (ctl_i.rd_en) begin
      lw_v_q <= ctl_i.we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      gv1_q     <= mix_rnd[PROD0_W-1:RND_SH];
      lw_addr_q <= ctl_i.wr_addr;
      lw_data_q <= wdata;
    end
    if (ctl_i.s2_en) begin
      gv2_q <= gv1_q;
      rp_q  <= rp_d;
    end
  end

  always_comb begin
    rp_rnd  = rp_q + PROD1_W'(ROUND);
    rend    = rp_rnd[PROD1_W-1:RND_SH];
    rend_hi = rend[REND_W-1:SAMP_W-1];
    if ((&rend_hi) || !(|rend_hi)) begin
      clip = rend[SAMP_W-1:0];
    end else begin
      clip = rend[REND_W-1] ? S_MIN : S_MAX;
    end
    if (!ctl_i.s2_render) begin
      val_o = gv2_q;
    end else if (ctl_i.s2_zero) begin
      val_o = '0;
    end else begin
      val_o = {{(VAL_W-SAMP_W){clip[SAMP_W-1]}}, clip};
    end
  end

endmodule

// ----- rtl/core/stereo_mix_bus_with_meters.sv -----
// top level of the stereo mix bus: config registers, item pipeline and peak meters
// One item per cycle is taken while the output does not stall; after acceptance
// each item passes the read of the frame's accumulator, accumulate or master
// multiply, round and clip, and peak merge into the output register. The left and
// right lanes each own a 1024 x 40 bit accumulator memory with one read and one
// write port, and a frame touched by the item just before is forwarded, so back to
// back items on the same frame keep full rate. After reset a clearing pass zeroes
// every frame of both accumulators while no item is accepted; configuration writes
// are taken at any time. The running peaks are shared by mix and render items, and
// a render or unmuted mix item that marks the last frame publishes and clears them.
module stereo_mix_bus_with_meters import smb_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         func_i,
  input  logic [STRIP_W-1:0]           strip_i,
  input  logic [FRAME_W-1:0]           frame_i,
  input  logic signed [SAMP_W-1:0]     in_left_i,
  input  logic signed [SAMP_W-1:0]     in_right_i,
  input  logic                         src_stereo_i,
  input  logic                         last_frame_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [SAMP_W-1:0]     out_left_o,
  output logic signed [SAMP_W-1:0]     out_right_o,
  output logic [PEAK_W-1:0]            peak_left_o,
  output logic [PEAK_W-1:0]            peak_right_o,
  output logic                         peak_valid_o,
  output logic                         ignored_o
);

  logic [GAIN_W-1:0] gain_q [MAX_STRIPS];
  logic [MUTE_W-1:0] mute_q;
  logic [GAIN_W-1:0] master_q;
  logic              stereo_q;

  logic              clr_busy_q;
  logic [AW-1:0]     clr_cnt_q;

  logic              v1_q, v2_q, v3_q, out_v_q;
  item_flags_t       f_in, f1_q, f2_q, f3_q;
  logic [AW-1:0]     frame1_q;
  logic signed [VAL_W-1:0] val_l, val_r, val_l3_q, val_r3_q;

  logic out_en, en3, en2, en1, acc_in, s1_go;
  logic strip_ok, muted, frame_ok, is_mix, mix_live, do_mix;
  logic [AW-1:0] in_addr, wr_addr;
  logic signed [SAMP_W-1:0] right_src;
  lane_ctl_t ctl_l, ctl_r;

  logic [PEAK_W-1:0] pk_l_q, pk_r_q, pk_l_new, pk_r_new;
  logic [VAL_W-1:0]  abs_l, abs_r;
  logic [PEAK_W-1:0] mag_l, mag_r;

  logic signed [SAMP_W-1:0] out_left_q, out_right_q;
  logic [PEAK_W-1:0] peak_left_q, peak_right_q;
  logic peak_valid_q, ignored_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_STRIPS; i++) begin
        gain_q[i] <= GAIN_UNITY;
      end
      mute_q   <= '0;
      master_q <= GAIN_UNITY;
      stereo_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_STRIP_GAIN_0: gain_q[0] <= cfg_data_i;
        REG_STRIP_GAIN_1: gain_q[1] <= cfg_data_i;
        REG_STRIP_GAIN_2: gain_q[2] <= cfg_data_i;
        REG_STRIP_GAIN_3: gain_q[3] <= cfg_data_i;
        REG_MUTE_MASK:    mute_q    <= cfg_data_i[MUTE_W-1:0];
        REG_MASTER_GAIN:  master_q  <= cfg_data_i;
        REG_STEREO_OUT:   stereo_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(FRAMES - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // pipeline flow
  assign out_en     = !out_v_q || out_ready_i;
  assign en3        = !v3_q || out_en;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = !clr_busy_q && en1;
  assign acc_in     = in_valid_i && in_ready_o;
  assign s1_go      = v1_q && en2;

  // item decode
  always_comb begin
    is_mix   = (func_i == FUNC_MIX);
    strip_ok = (32'(strip_i) < 32'(NUM_STRIPS));
    muted    = mute_q[strip_i];
    frame_ok = (32'(frame_i) < 32'(FRAMES));
    in_addr  = AW'(frame_i);
    mix_live = is_mix && strip_ok && !muted;
    do_mix   = mix_live && frame_ok;

    f_in.render  = (func_i == FUNC_RENDER);
    f_in.track   = do_mix || (f_in.render && frame_ok);
    f_in.publish = last_frame_i && (f_in.render || mix_live);
    f_in.ignored = is_mix && strip_ok && muted;
    f_in.wr_l    = do_mix || (f_in.render && frame_ok);
    f_in.wr_r    = (do_mix && stereo_q) || (f_in.render && frame_ok);
    f_in.zero_l  = !frame_ok;
    f_in.zero_r  = !frame_ok || !stereo_q;
    right_src    = src_stereo_i ? in_right_i : in_left_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1) v1_q <= acc_in;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (out_en) out_v_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      f1_q     <= f_in;
      frame1_q <= in_addr;
    end
    if (en2) f2_q <= f1_q;
    if (en3) begin
      f3_q     <= f2_q;
      val_l3_q <= val_l;
      val_r3_q <= val_r;
    end
  end

  // lane control
  assign wr_addr = clr_busy_q ? clr_cnt_q : frame1_q;

  always_comb begin
    ctl_l.rd_en     = acc_in;
    ctl_l.rd_addr   = in_addr;
    ctl_l.s1_addr   = frame1_q;
    ctl_l.we        = clr_busy_q || (s1_go && f1_q.wr_l);
    ctl_l.wr_sum    = !clr_busy_q && !f1_q.render;
    ctl_l.wr_addr   = wr_addr;
    ctl_l.s2_en     = en2;
    ctl_l.s2_render = f2_q.render;
    ctl_l.s2_zero   = f2_q.zero_l;
    ctl_r           = ctl_l;
    ctl_r.we        = clr_busy_q || (s1_go && f1_q.wr_r);
    ctl_r.s2_zero   = f2_q.zero_r;
  end

  smb_lane u_lane_l (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl_l),
    .sample_i (in_left_i),
    .gain_i   (gain_q[strip_i]),
    .master_i (master_q),
    .val_o    (val_l)
  );

  smb_lane u_lane_r (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl_r),
    .sample_i (right_src),
    .gain_i   (gain_q[strip_i]),
    .master_i (master_q),
    .val_o    (val_r)
  );

  // peak merge
  always_comb begin
    abs_l = val_l3_q[VAL_W-1] ? VAL_W'(-val_l3_q) : VAL_W'(val_l3_q);
    abs_r = val_r3_q[VAL_W-1] ? VAL_W'(-val_r3_q) : VAL_W'(val_r3_q);
    mag_l = (|abs_l[VAL_W-1:PEAK_W]) ? PEAK_MAX : abs_l[PEAK_W-1:0];
    mag_r = (|abs_r[VAL_W-1:PEAK_W]) ? PEAK_MAX : abs_r[PEAK_W-1:0];
    pk_l_new = (f3_q.track && (mag_l > pk_l_q)) ? mag_l : pk_l_q;
    pk_r_new = (f3_q.track && (mag_r > pk_r_q)) ? mag_r : pk_r_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pk_l_q <= '0;
      pk_r_q <= '0;
    end else if (v3_q && out_en) begin
      pk_l_q <= f3_q.publish ? '0 : pk_l_new;
      pk_r_q <= f3_q.publish ? '0 : pk_r_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_left_q   <= f3_q.render ? val_l3_q[SAMP_W-1:0] : '0;
      out_right_q  <= f3_q.render ? val_r3_q[SAMP_W-1:0] : '0;
      peak_left_q  <= f3_q.publish ? pk_l_new : '0;
      peak_right_q <= f3_q.publish ? pk_r_new : '0;
      peak_valid_q <= f3_q.publish;
      ignored_q    <= f3_q.ignored;
    end
  end

  assign out_valid_o  = out_v_q;
  assign out_left_o   = out_left_q;
  assign out_right_o  = out_right_q;
  assign peak_left_o  = peak_left_q;
  assign peak_right_o = peak_right_q;
  assign peak_valid_o = peak_valid_q;
  assign ignored_o    = ignored_q;

endmodule

// ----- tb/sv/smb_bus_checker.sv -----
// checker of the stereo mix bus: watches all channels, predicts each result and compares
module smb_bus_checker
  import smb_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic                     func_i,
  input  logic [STRIP_W-1:0]       strip_i,
  input  logic [FRAME_W-1:0]       frame_i,
  input  logic signed [SAMP_W-1:0] in_left_i,
  input  logic signed [SAMP_W-1:0] in_right_i,
  input  logic                     src_stereo_i,
  input  logic                     last_frame_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [SAMP_W-1:0] out_left_i,
  input  logic signed [SAMP_W-1:0] out_right_i,
  input  logic [PEAK_W-1:0]        peak_left_i,
  input  logic [PEAK_W-1:0]        peak_right_i,
  input  logic                     peak_valid_i,
  input  logic                     ignored_i,
  output int                       fail_count_o,
  output int                       pending_o,
  output int                       results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SUM_HI  = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO  = -SUM_HI - 1;
  localparam longint SAMP_HI = (longint'(1) <<< (SAMP_W - 1)) - 1;
  localparam longint SAMP_LO = -SAMP_HI - 1;

  typedef struct packed {
    logic [SAMP_W-1:0] left;
    logic [SAMP_W-1:0] right;
    logic [PEAK_W-1:0] pk_left;
    logic [PEAK_W-1:0] pk_right;
    logic              pk_valid;
    logic              ignored;
  } bus_result_t;

  longint            sum_l [FRAMES];
  longint            sum_r [FRAMES];
  logic [PEAK_W-1:0] peak_run_l;
  logic [PEAK_W-1:0] peak_run_r;
  logic [GAIN_W-1:0] gain_q [NUM_STRIPS];
  logic [MUTE_W-1:0] mute_q;
  logic [GAIN_W-1:0] master_q;
  logic              stereo_q;
  bus_result_t       mix_results_q [$];
  int                fails;
  int                checked;

  // q4.12 gain with round half up
  function automatic longint scaled(longint x, logic [GAIN_W-1:0] g);
    longint v;
    v = x * longint'(g) + longint'(ROUND);
    return v >>> RND_SH;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [PEAK_W-1:0] peak_of(logic [PEAK_W-1:0] pk, longint v);
    longint mag;
    mag = (v < 0) ? -v : v;
    if (mag > longint'(PEAK_MAX)) mag = longint'(PEAK_MAX);
    return (mag > longint'(pk)) ? PEAK_W'(mag) : pk;
  endfunction

  function automatic bus_result_t next_bus_result(logic f, logic [STRIP_W-1:0] s,
                                                  logic [FRAME_W-1:0] fr, longint l,
                                                  longint r, logic src, logic last);
    bus_result_t res;
    longint      vl;
    longint      vr;
    res = '0;
    if (f == FUNC_MIX) begin
      if (int'(s) >= NUM_STRIPS) return res;
      if (mute_q[s]) begin
        res.ignored = 1'b1;
        return res;
      end
      vl = scaled(l, gain_q[s]);
      vr = src ? scaled(r, gain_q[s]) : vl;
      sum_l[fr] = clip(sum_l[fr] + vl, SUM_LO, SUM_HI);
      if (stereo_q) sum_r[fr] = clip(sum_r[fr] + vr, SUM_LO, SUM_HI);
    end else begin
      vl = clip(scaled(sum_l[fr], master_q), SAMP_LO, SAMP_HI);
      vr = stereo_q ? clip(scaled(sum_r[fr], master_q), SAMP_LO, SAMP_HI) : 0;
      sum_l[fr] = 0;
      sum_r[fr] = 0;
      res.left  = SAMP_W'(vl);
      res.right = SAMP_W'(vr);
    end
    peak_run_l = peak_of(peak_run_l, vl);
    peak_run_r = peak_of(peak_run_r, vr);
    if (last) begin
      res.pk_left  = peak_run_l;
      res.pk_right = peak_run_r;
      res.pk_valid = 1'b1;
      peak_run_l   = '0;
      peak_run_r   = '0;
    end
    return res;
  endfunction

  task automatic field_check(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bus_result_t want;
    if (!rst_ni) begin
      foreach (sum_l[i]) begin
        sum_l[i] = 0;
        sum_r[i] = 0;
      end
      foreach (gain_q[i]) gain_q[i] = GAIN_UNITY;
      peak_run_l = '0;
      peak_run_r = '0;
      mute_q     = '0;
      master_q   = GAIN_UNITY;
      stereo_q   = 1'b1;
      mix_results_q.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_STRIP_GAIN_0: gain_q[0] = cfg_data_i[GAIN_W-1:0];
          REG_STRIP_GAIN_1: gain_q[1] = cfg_data_i[GAIN_W-1:0];
          REG_STRIP_GAIN_2: gain_q[2] = cfg_data_i[GAIN_W-1:0];
          REG_STRIP_GAIN_3: gain_q[3] = cfg_data_i[GAIN_W-1:0];
          REG_MUTE_MASK:    mute_q    = cfg_data_i[MUTE_W-1:0];
          REG_MASTER_GAIN:  master_q  = cfg_data_i[GAIN_W-1:0];
          REG_STEREO_OUT:   stereo_q  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        mix_results_q.push_back(next_bus_result(func_i, strip_i, frame_i, longint'(in_left_i),
                                                longint'(in_right_i), src_stereo_i,
                                                last_frame_i));
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (mix_results_q.size() == 0) begin
          $error("result arrived with no item outstanding");
          fails++;
        end else begin
          want = mix_results_q.pop_front();
          field_check("out_left", $signed(want.left), out_left_i);
          field_check("out_right", $signed(want.right), out_right_i);
          field_check("peak_left", want.pk_left, peak_left_i);
          field_check("peak_right", want.pk_right, peak_right_i);
          field_check("peak_valid", want.pk_valid, peak_valid_i);
          field_check("ignored", want.ignored, ignored_i);
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= mix_results_q.size();
    results_o    <= checked;
  end

endmodule

// ----- tb/sv/tb_stereo_mix_bus_with_meters.sv -----
// testbench top of the stereo mix bus: clock, reset, stimulus, output stalls and verdict
module tb_stereo_mix_bus_with_meters;
  timeunit 1ns;
  timeprecision 1ps;
  import smb_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 600;
  localparam int SAT_ITEMS   = 300;
  localparam int PHASES      = 4;
  localparam int PHASE_ITEMS = 220;

  localparam logic [SAMP_W-1:0] SAMPLE_MAX = {1'b0, {(SAMP_W-1){1'b1}}};
  localparam logic [SAMP_W-1:0] SAMPLE_MIN = {1'b1, {(SAMP_W-1){1'b0}}};

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     cfg_valid  = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index  = '0;
  logic [CFG_DATA_W-1:0]    cfg_data   = '0;
  logic                     in_valid   = 1'b0;
  logic                     in_ready;
  logic                     func       = FUNC_MIX;
  logic [STRIP_W-1:0]       strip      = '0;
  logic [FRAME_W-1:0]       frame      = '0;
  logic signed [SAMP_W-1:0] in_left    = '0;
  logic signed [SAMP_W-1:0] in_right   = '0;
  logic                     src_stereo = 1'b0;
  logic                     last_frame = 1'b0;
  logic                     out_valid;
  logic                     out_ready  = 1'b0;
  logic signed [SAMP_W-1:0] out_left;
  logic signed [SAMP_W-1:0] out_right;
  logic [PEAK_W-1:0]        peak_left;
  logic [PEAK_W-1:0]        peak_right;
  logic                     peak_valid;
  logic                     ignored;

  int fail_count;
  int pending;
  int results;
  int sent        = 0;
  int settings    = 0;
  int idle_cycles = 0;
  bit dense       = 1'b0;

  initial forever #1 clk = ~clk;

  stereo_mix_bus_with_meters uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .func_i       (func),
    .strip_i      (strip),
    .frame_i      (frame),
    .in_left_i    (in_left),
    .in_right_i   (in_right),
    .src_stereo_i (src_stereo),
    .last_frame_i (last_frame),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_left_o   (out_left),
    .out_right_o  (out_right),
    .peak_left_o  (peak_left),
    .peak_right_o (peak_right),
    .peak_valid_o (peak_valid),
    .ignored_o    (ignored)
  );

  smb_bus_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .func_i       (func),
    .strip_i      (strip),
    .frame_i      (frame),
    .in_left_i    (in_left),
    .in_right_i   (in_right),
    .src_stereo_i (src_stereo),
    .last_frame_i (last_frame),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_left_i   (out_left),
    .out_right_i  (out_right),
    .peak_left_i  (peak_left),
    .peak_right_i (peak_right),
    .peak_valid_i (peak_valid),
    .ignored_i    (ignored),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results)
  );

  // mostly none or short, now and then long
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [SAMP_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return {SAMP_W{1'b1}};
      3, 4:    return SAMP_W'(int'($urandom_range(0, 8191)) - 4096);
      default: return SAMP_W'($urandom());
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'(1);
      3:       return GAIN_UNITY;
      default: return GAIN_W'($urandom_range(512, 8192));
    endcase
  endfunction

  task automatic send(input logic f, input int s, input int fr, input logic [SAMP_W-1:0] l,
                      input logic [SAMP_W-1:0] r, input logic src, input logic last);
    int gap;
    in_valid   <= 1'b1;
    func       <= f;
    strip      <= STRIP_W'(s);
    frame      <= FRAME_W'(fr);
    in_left    <= l;
    in_right   <= r;
    src_stereo <= src;
    last_frame <= last;
    do @(posedge clk); while (!in_ready);
    sent++;
    gap = dense ? 0 : pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // unused upper data bits of the narrow registers carry junk
  task automatic write_regs(input logic [GAIN_W-1:0] g0, input logic [GAIN_W-1:0] g1,
                            input logic [GAIN_W-1:0] g2, input logic [GAIN_W-1:0] g3,
                            input logic [MUTE_W-1:0] mute, input logic [GAIN_W-1:0] master,
                            input logic stereo);
    logic [CFG_IDX_W-1:0]  idx [7];
    logic [CFG_DATA_W-1:0] val [7];
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom());
    idx  = '{REG_STRIP_GAIN_0, REG_STRIP_GAIN_1, REG_STRIP_GAIN_2, REG_STRIP_GAIN_3,
             REG_MUTE_MASK, REG_MASTER_GAIN, REG_STEREO_OUT};
    val  = '{g0, g1, g2, g3, {junk[CFG_DATA_W-1:MUTE_W], mute}, master,
             {junk[CFG_DATA_W-2:0], stereo}};
    for (int i = 0; i < 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  initial begin
    bit squeezed;
    squeezed = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!squeezed && results >= HOLD_AFTER) begin
        squeezed = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 4) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(30, 120)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_ready <= 1'b0;
        repeat (pause_len() + 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** stereo_mix_bus_with_meters: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unity gains, stereo bus
    write_regs(GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, '0, GAIN_UNITY, 1'b1);
    send(FUNC_MIX, 0, 0, SAMPLE_MAX, SAMPLE_MIN, 1'b1, 1'b0);
    send(FUNC_MIX, 1, 0, SAMPLE_MIN, SAMPLE_MAX, 1'b0, 1'b0);
    send(FUNC_MIX, 2, FRAMES - 1, {SAMP_W{1'b1}}, SAMP_W'(1), 1'b1, 1'b1);
    send(FUNC_MIX, 3, FRAMES / 2, '0, '0, 1'b1, 1'b1);
    send(FUNC_RENDER, 0, 0, SAMPLE_MAX, SAMPLE_MIN, 1'b0, 1'b0);
    send(FUNC_RENDER, 3, FRAMES - 1, '0, '1, 1'b1, 1'b0);
    send(FUNC_RENDER, 1, 5, '0, '0, 1'b0, 1'b1);
    send(FUNC_RENDER, 2, 0, '1, '0, 1'b1, 1'b1);
    settle();

    // extreme gains, two strips muted, mono bus
    write_regs('1, '0, GAIN_W'(1), GAIN_UNITY, 4'b1010, '1, 1'b0);
    send(FUNC_MIX, 0, 7, SAMPLE_MAX, SAMPLE_MIN, 1'b1, 1'b0);
    send(FUNC_MIX, 1, 7, SAMPLE_MAX, SAMPLE_MAX, 1'b1, 1'b1);
    send(FUNC_MIX, 3, 7, SAMPLE_MIN, SAMPLE_MIN, 1'b0, 1'b0);
    send(FUNC_MIX, 2, 7, SAMPLE_MIN, SAMPLE_MAX, 1'b1, 1'b1);
    send(FUNC_MIX, 3, 8, SAMPLE_MAX, SAMPLE_MAX, 1'b1, 1'b1);
    send(FUNC_MIX, 0, 8, SAMPLE_MIN, SAMPLE_MIN, 1'b0, 1'b0);
    send(FUNC_RENDER, 0, 7, '0, '0, 1'b0, 1'b0);
    send(FUNC_RENDER, 0, 8, '0, '0, 1'b0, 1'b1);
    settle();

    // everything muted, master gain zero
    write_regs(GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, '1, '0, 1'b1);
    send(FUNC_MIX, 0, 9, SAMPLE_MAX, SAMPLE_MAX, 1'b1, 1'b1);
    send(FUNC_RENDER, 0, 9, '0, '0, 1'b0, 1'b1);
    settle();

    // pile one frame up on both rails at full gain, then render it clipped
    write_regs('1, '1, '1, '1, '0, GAIN_W'(1), 1'b1);
    dense = 1'b1;
    for (int n = 0; n < SAT_ITEMS; n++)
      send(FUNC_MIX, n % NUM_STRIPS, 3, SAMPLE_MAX, SAMPLE_MIN, 1'b1, n == SAT_ITEMS - 1);
    send(FUNC_RENDER, 0, 3, '0, '0, 1'b0, 1'b1);
    dense = 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      int goal;
      settle();
      write_regs(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                 ($urandom_range(0, 3) == 0) ? MUTE_W'($urandom_range(1, 15)) : '0,
                 pick_gain(), 1'($urandom_range(0, 1)));
      goal = sent + PHASE_ITEMS;
      while (sent < goal) begin
        int                    base;
        int                    span;
        logic [NUM_STRIPS-1:0] used;
        logic                  src;
        dense = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 6))
            send(1'($urandom_range(0, 1)), $urandom_range(0, NUM_STRIPS - 1),
                 $urandom_range(0, FRAMES - 1), pick_sample(), pick_sample(),
                 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
        end else begin
          // one buffer call: strips mix a run of frames, then the run is rendered
          base = $urandom_range(0, FRAMES - 8);
          span = $urandom_range(1, 8);
          used = NUM_STRIPS'($urandom_range(1, (1 << NUM_STRIPS) - 1));
          for (int s = 0; s < NUM_STRIPS; s++)
            if (used[s]) begin
              src = 1'($urandom_range(0, 1));
              for (int f = 0; f < span; f++)
                send(FUNC_MIX, s, base + f, pick_sample(), pick_sample(), src,
                     f == span - 1);
            end
          for (int f = 0; f < span; f++)
            send(FUNC_RENDER, $urandom_range(0, NUM_STRIPS - 1), base + f, pick_sample(),
                 pick_sample(), 1'($urandom_range(0, 1)), f == span - 1);
        end
      end
    end
    settle();

    $display("%0d items sent and %0d results checked over %0d register settings,",
             sent, results, settings);
    $display("including a %0d-item full-gain pile-up on one frame and a %0d-cycle output hold-off",
             SAT_ITEMS, HOLD_CYCLES);
    if (fail_count == 0 && pending == 0)
      $display("** stereo_mix_bus_with_meters: PASSED **");
    else
      $display("** stereo_mix_bus_with_meters: FAILED **");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/smb_pkg.sv
rtl/core/smb_ram.sv
rtl/core/smb_lane.sv
rtl/core/stereo_mix_bus_with_meters.sv
tb/sv/smb_bus_checker.sv
tb/sv/tb_stereo_mix_bus_with_meters.sv
